// ===== rtl/msp_pkg.sv =====
// Package for the matrix saddle point search block.
// Holds the word types, sizes, register indexes and sequencer states.
// Used by the top level and by the checker; depends on nothing.
package msp_pkg;

  localparam int MSP_MAX_ROWS    = 8;
  localparam int MSP_MAX_COLUMNS = 8;

  localparam int IDX_W   = 3;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FIND  = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        column_index;
    logic signed [VAL_W-1:0] element_value;
  } msp_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] point_value;
    logic [IDX_W-1:0]        point_row;
    logic [IDX_W-1:0]        point_column;
    logic                    is_point;
    logic                    last_point;
  } msp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_MAX,
    ST_SCAN,
    ST_FLUSH,
    ST_FINAL
  } msp_state_t;

endpackage

// ===== rtl/msp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the matrix store; depends on nothing.
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/matrix_saddle_point_search.sv =====
// A write word gives no result and leaves busy low, so writes go one per cycle while idle.
// A find word keeps busy high until the search over the rows and columns in use is done.
// Three passes walk the store, one element per cycle through its single read port
// and one compare unit.
// Each result is strobed when the next one is found; the final one is strobed as busy falls.
// Synchronous reset marks the store unwritten so it reads as zero, sets the counts to eight and the sequencer to idle.
module matrix_saddle_point_search import msp_pkg::*; #(
  parameter int MAX_ROWS    = MSP_MAX_ROWS,
  parameter int MAX_COLUMNS = MSP_MAX_COLUMNS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  msp_in_t              item,
  output logic                 strobe,
  output msp_out_t             result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  msp_state_t state, state_next;

  logic [CNT_W-1:0] row_count, column_count;
  logic [CNT_W-1:0] rows_used, cols_used;

  logic [RW-1:0] r, r_next;
  logic [CW-1:0] c, c_next;
  logic issue, end_col, last_cell;

  logic          d_v;
  msp_state_t    d_state;
  logic [RW-1:0] d_r;
  logic [CW-1:0] d_c;
  logic          d_written;

  logic [DEPTH-1:0] written;
  logic [AW-1:0]    raddr, waddr;
  logic             we;
  logic [VAL_W-1:0] rdata;

  logic signed [VAL_W-1:0] row_min [MAX_ROWS];
  logic signed [VAL_W-1:0] col_max [MAX_COLUMNS];

  logic signed [VAL_W-1:0] data, operand;
  logic lt, eq, eq_row, match;

  logic     pend_v;
  msp_out_t pend;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= COUNT_RESET;
      column_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_count == '0) begin
      rows_used = CNT_W'(1);
    end else if (row_count > CNT_W'(MAX_ROWS)) begin
      rows_used = CNT_W'(MAX_ROWS);
    end else begin
      rows_used = row_count;
    end
    if (column_count == '0) begin
      cols_used = CNT_W'(1);
    end else if (column_count > CNT_W'(MAX_COLUMNS)) begin
      cols_used = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_used = column_count;
    end
  end

  // Element writes go straight into the store while idle.
  assign we = start && !busy && (item.command == CMD_WRITE)
              && (CNT_W'(item.row_index) < CNT_W'(MAX_ROWS))
              && (CNT_W'(item.column_index) < CNT_W'(MAX_COLUMNS));
  assign waddr = AW'(AW'(RW'(item.row_index)) * AW'(MAX_COLUMNS) + AW'(CW'(item.column_index)));
  assign raddr = AW'(AW'(r) * AW'(MAX_COLUMNS) + AW'(c));

  msp_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(item.element_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r     <= '0;
      c     <= '0;
      d_v   <= 1'b0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      d_v   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    d_state   <= state;
    d_r       <= r;
    d_c       <= c;
    d_written <= written[raddr];
  end

  always_comb begin
    issue      = (state == ST_MIN) || (state == ST_MAX) || (state == ST_SCAN);
    end_col    = (CNT_W'(c) == cols_used - CNT_W'(1));
    last_cell  = end_col && (CNT_W'(r) == rows_used - CNT_W'(1));
    state_next = state;
    r_next     = r;
    c_next     = c;
    if (issue) begin
      if (end_col) begin
        c_next = '0;
        r_next = last_cell ? '0 : RW'(r + RW'(1));
      end else begin
        c_next = CW'(c + CW'(1));
      end
    end
    case (state)
      ST_IDLE: begin
        if (start && (item.command == CMD_FIND)) begin
          state_next = ST_MIN;
          r_next     = '0;
          c_next     = '0;
        end
      end
      ST_MIN:   if (last_cell) state_next = ST_MAX;
      ST_MAX:   if (last_cell) state_next = ST_SCAN;
      ST_SCAN:  if (last_cell) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_FINAL;
      ST_FINAL: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // The one compare unit serves all three passes.
  always_comb begin
    data    = d_written ? $signed(rdata) : '0;
    operand = (d_state == ST_MIN) ? row_min[d_r] : col_max[d_c];
    lt      = data < operand;
    eq      = data == operand;
    eq_row  = data == row_min[d_r];
    match   = d_v && (d_state == ST_SCAN) && eq && eq_row;
  end

  always_ff @(posedge clk) begin
    if (d_v) begin
      case (d_state)
        ST_MIN: if (d_c == '0 || lt) row_min[d_r] <= data;
        ST_MAX: if (d_r == '0 || (!lt && !eq)) col_max[d_c] <= data;
        default: ;
      endcase
    end
  end

  // A found point is held back one step so the final one can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend_v <= 1'b0;
    end else if (state == ST_FINAL) begin
      strobe <= 1'b1;
      pend_v <= 1'b0;
    end else if (match) begin
      strobe <= pend_v;
      pend_v <= 1'b1;
    end else begin
      strobe <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL) begin
      if (pend_v) begin
        result <= '{pend.point_value, pend.point_row, pend.point_column, pend.is_point, 1'b1};
      end else begin
        result.point_value  <= '0;
        result.point_row    <= '0;
        result.point_column <= '0;
        result.is_point     <= 1'b0;
        result.last_point   <= 1'b1;
      end
    end else if (match) begin
      result             <= pend;
      pend.point_value   <= data;
      pend.point_row     <= IDX_W'(d_r);
      pend.point_column  <= IDX_W'(d_c);
      pend.is_point      <= 1'b1;
      pend.last_point    <= 1'b0;
    end
  end

endmodule

// ===== rtl/msp_checker.sv =====
// Port-level checker for the matrix saddle point search block.
// Depends on msp_pkg; bound to the top level at the end of this file.
module msp_checker import msp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input msp_in_t              item,
  input logic                 strobe,
  input msp_out_t             result
);

  a_find_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == CMD_FIND |=> busy)
    else $error("find word did not raise busy");

  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.command == CMD_WRITE |=> !busy)
    else $error("write word raised busy");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.is_point |-> result.last_point)
    else $error("empty result not marked last");

  a_end_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && result.last_point)
    else $error("search ended without a final result");

  a_idle_strobe_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !busy |-> result.last_point)
    else $error("result strobed while idle was not the final one");

endmodule

bind matrix_saddle_point_search msp_checker u_msp_checker (.*);
